@@ hdl/slpp_pkg.sv @@
package slpp_pkg;

  // Q23.16 sample position and the wider sum used before clamping
  localparam int unsigned POS_W = 40;
  localparam int unsigned SUM_W = POS_W + 2;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned FRAC_DROP = 24;
  localparam int unsigned PROD_W = RATE_W + RECIP_W + 2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_RECIP   = 3'd4;

  // Loop modes and item functions
  localparam logic MODE_FORWARD  = 1'b0;
  localparam logic MODE_PINGPONG = 1'b1;
  localparam logic FUNC_STEP     = 1'b0;
  localparam logic FUNC_RESTART  = 1'b1;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd97392;

  localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Clamp a widened sum to the position range
  function automatic pos_t sat_pos(input sum_t v);
    pos_t res;
    if (v > sum_t'(POS_MAX)) begin
      res = POS_MAX;
    end else if (v < sum_t'(POS_MIN)) begin
      res = POS_MIN;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/sustain_loop_position_phasor.sv @@
// Path: stage 1, stage 2, result register; the loop state updates from stage 2.
// Throughput: one item per cycle while no result is stalled.
// The increment multiply (32x32) sits in its own stage ahead of the loop fold.
// A restart item updates state and produces no result.
// Reset (rst_n low, synchronous): pipeline emptied, position 0, direction forward,
// loop registers 0, forward mode, sample-rate reciprocal 97392.
module sustain_loop_position_phasor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic signed [slpp_pkg::RATE_W-1:0]   in_rate,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [slpp_pkg::POS_W-1:0]    out_position,
  input  logic                                 cfg_we,
  input  logic [slpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [slpp_pkg::POS_W-1:0]           cfg_wdata
);

  // Configuration registers
  slpp_pkg::pos_t                    loop_start_r;
  slpp_pkg::pos_t                    loop_end_r;
  slpp_pkg::pos_t                    start_offset_r;
  logic                              loop_mode_r;
  logic [slpp_pkg::RECIP_W-1:0]      rate_recip_r;

  // Pipeline registers
  logic                              s1_valid_r;
  logic                              s1_func_r;
  logic signed [slpp_pkg::RATE_W-1:0] s1_rate_r;
  logic                              s2_valid_r;
  logic                              s2_func_r;
  slpp_pkg::pos_t                    s2_inc_r;
  logic                              out_valid_r;
  slpp_pkg::pos_t                    out_position_r;

  // Loop state
  slpp_pkg::pos_t                    pos_r;
  logic                              back_r;

  logic                              advance;
  logic signed [slpp_pkg::PROD_W-1:0] prod;
  slpp_pkg::pos_t                    inc_nxt;
  slpp_pkg::sum_t                    p_w;
  slpp_pkg::sum_t                    start_w;
  slpp_pkg::sum_t                    end_w;
  slpp_pkg::sum_t                    inc_w;
  slpp_pkg::pos_t                    fwd_wrap;
  slpp_pkg::pos_t                    pp_hi;
  slpp_pkg::pos_t                    pp_lo;
  logic                              gt_end;
  logic                              lt_start;
  slpp_pkg::pos_t                    folded;
  logic                              back_fold;
  slpp_pkg::pos_t                    pos_nxt;
  slpp_pkg::sum_t                    fold_w;

  // The whole pipeline moves unless a result waits and is stalled
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = out_valid_r;
  assign out_position = out_position_r;

  // Increment: rate (Q23.8) times reciprocal (Q0.32), floor to Q23.16
  assign prod    = slpp_pkg::PROD_W'(s1_rate_r) *
                   $signed({{(slpp_pkg::PROD_W-slpp_pkg::RECIP_W){1'b0}}, rate_recip_r});
  assign inc_nxt = prod[slpp_pkg::FRAC_DROP+slpp_pkg::POS_W-1:slpp_pkg::FRAC_DROP];

  // Fold the stored position into the loop
  assign p_w     = slpp_pkg::sum_t'(pos_r);
  assign start_w = slpp_pkg::sum_t'(loop_start_r);
  assign end_w   = slpp_pkg::sum_t'(loop_end_r);
  assign inc_w   = slpp_pkg::sum_t'(s2_inc_r);
  assign gt_end   = pos_r > loop_end_r;
  assign lt_start = pos_r < loop_start_r;
  assign fwd_wrap = slpp_pkg::sat_pos(start_w + p_w - end_w);
  assign pp_hi    = slpp_pkg::sat_pos(end_w + end_w - p_w);
  assign pp_lo    = slpp_pkg::sat_pos(start_w + start_w - p_w);

  always_comb begin
    folded    = pos_r;
    back_fold = back_r;
    if (loop_mode_r == slpp_pkg::MODE_FORWARD) begin
      if (gt_end) begin
        folded = fwd_wrap;
      end
    end else begin
      if (gt_end) begin
        folded    = pp_hi;
        back_fold = 1'b1;
      end else if (lt_start && back_r) begin
        folded    = pp_lo;
        back_fold = 1'b0;
      end
    end
  end

  // Advance along the current direction
  assign fold_w  = slpp_pkg::sum_t'(folded);
  assign pos_nxt = (loop_mode_r == slpp_pkg::MODE_PINGPONG && back_fold) ?
                   slpp_pkg::sat_pos(fold_w - inc_w) :
                   slpp_pkg::sat_pos(fold_w + inc_w);

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func_r <= in_func;
      s1_rate_r <= in_rate;
      s2_func_r <= s1_func_r;
      s2_inc_r  <= inc_nxt;
      if (s2_valid_r && s2_func_r == slpp_pkg::FUNC_STEP) begin
        out_position_r <= folded;
      end
    end
  end

  // Control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pos_r          <= '0;
      back_r         <= 1'b0;
      loop_start_r   <= '0;
      loop_end_r     <= '0;
      start_offset_r <= '0;
      loop_mode_r    <= slpp_pkg::MODE_FORWARD;
      rate_recip_r   <= slpp_pkg::RECIP_RESET;
    end else begin
      if (advance) begin
        s1_valid_r  <= in_valid;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r && s2_func_r == slpp_pkg::FUNC_STEP;
        if (s2_valid_r) begin
          if (s2_func_r == slpp_pkg::FUNC_RESTART) begin
            pos_r  <= start_offset_r;
            back_r <= 1'b0;
          end else begin
            pos_r  <= pos_nxt;
            back_r <= back_fold;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          slpp_pkg::CFG_LOOP_START:   loop_start_r   <= cfg_wdata;
          slpp_pkg::CFG_LOOP_END:     loop_end_r     <= cfg_wdata;
          slpp_pkg::CFG_START_OFFSET: start_offset_r <= cfg_wdata;
          slpp_pkg::CFG_LOOP_MODE: begin
            loop_mode_r <= cfg_wdata[0];
            if (cfg_wdata[0] == slpp_pkg::MODE_PINGPONG) begin
              back_r <= 1'b0;
            end
          end
          slpp_pkg::CFG_RATE_RECIP:   rate_recip_r <= cfg_wdata[slpp_pkg::RECIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/slpp_checker.sv @@
module slpp_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_stall,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [slpp_pkg::POS_W-1:0]    out_position
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position))
    else $error("stalled result changed");

  // Input side stalls only behind a waiting, stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // The output stays empty just after the first edge with reset released
  a_reset_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_valid)
    else $error("result appeared before pipeline latency");

endmodule

bind sustain_loop_position_phasor slpp_checker u_slpp_checker (.*);
